@@ src/deq_pkg.sv @@
package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    typedef logic [DATA_W-1:0] t_data;

    // what a cell loads on the next edge
    typedef enum logic [1:0] {
        MODE_HOLD       = 2'd0,
        MODE_FROM_LEFT  = 2'd1,
        MODE_FROM_RIGHT = 2'd2,
        MODE_LOAD       = 2'd3
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic       occupied;
    } t_cell_ctrl;

endpackage

@@ src/deq_cell.sv @@
module deq_cell
    import deq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_data      i_key,
    input  t_data      i_left,
    input  t_data      i_right,
    input  logic       i_seen,
    output t_data      o_data,
    output logic       o_match,
    output logic       o_seen
);

    t_data r_data;
    t_data n_data;

    always_comb begin
        case (i_ctrl.mode)
            MODE_FROM_LEFT:  n_data = i_left;
            MODE_FROM_RIGHT: n_data = i_right;
            MODE_LOAD:       n_data = i_key;
            default:         n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = i_ctrl.occupied && (r_data == i_key);
    // running "match at or before this cell" along the row
    assign o_seen  = i_seen | o_match;

endmodule

@@ src/deque_with_value_removal_core.sv @@
// channel | valid       | ready       | payload
// --------+-------------+-------------+-----------------------------------------
// request | i_in_valid  | o_in_ready  | i_kind, i_value
// result  | o_out_valid | i_out_ready | o_removed_value, o_status, o_occupancy
//
// one transaction per cycle unless a held result waits on i_out_ready: the whole
// row of cells shifts, loads or holds at once, and the row search plus the result
// register set the path. the result is registered and appears in the cycle after
// the request is taken. reset clears the count and the result valid flag; cell
// contents and the result payload are not reset.
// a held result blocks new requests only while i_out_ready is low.
module deque_with_value_removal_core
    import deq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_removed_value,
    output logic [STAT_W-1:0]        o_status,
    output logic [OCC_W-1:0]         o_occupancy
);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    t_data             r_removed;
    t_data             n_removed;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [CNT_W-1:0]  r_occ;

    t_data             w_key;
    t_data             w_data  [DEPTH];
    logic [DEPTH-1:0]  w_match;
    logic [DEPTH:0]    w_seen;
    logic [DEPTH-1:0]  w_last;
    logic [DEPTH-1:0]  w_tail;
    logic [DEPTH-1:0]  w_occ;
    t_cell_ctrl        w_ctrl  [DEPTH];
    logic              w_go;
    logic              w_full;
    logic              w_empty;
    logic              w_front_hit;
    logic              w_back_hit;
    logic              w_found;
    t_data             w_back_data;

    assign w_key      = i_value;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_go       = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_seen[0]  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
            localparam logic [CNT_W-1:0] IDX1 = CNT_W'(g + 1);

            assign w_occ[g]  = (IDX < r_count);
            assign w_last[g] = (IDX1 == r_count);
            assign w_tail[g] = (IDX1 >= r_count);

            deq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl[g]),
                .i_key   (w_key),
                .i_left  ((g == 0) ? t_data'('0) : w_data[(g == 0) ? 0 : g - 1]),
                .i_right ((g == DEPTH - 1) ? t_data'('0)
                                           : w_data[(g == DEPTH - 1) ? g : g + 1]),
                .i_seen  (w_seen[g]),
                .o_data  (w_data[g]),
                .o_match (w_match[g]),
                .o_seen  (w_seen[g+1])
            );
        end
    endgenerate

    assign w_front_hit = w_match[0];
    assign w_back_hit  = |(w_match & w_last);
    assign w_found     = w_seen[DEPTH];

    always_comb begin
        w_back_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back_data = w_back_data | (w_data[i] & {DATA_W{w_last[i]}});
        end
    end

    // per-cell control and the result of this request
    always_comb begin
        logic rm;
        rm        = 1'b0;
        n_count   = r_count;
        n_status  = ST_OK;
        n_removed = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_ctrl[i].occupied = w_occ[i];
            w_ctrl[i].mode     = MODE_HOLD;
        end
        unique case (i_kind)
            KIND_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    for (int i = 0; i < DEPTH; i++) begin
                        w_ctrl[i].mode = (i == 0) ? MODE_LOAD : MODE_FROM_LEFT;
                    end
                end
            end
            KIND_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CNT_W'(i) == r_count) w_ctrl[i].mode = MODE_LOAD;
                    end
                end
            end
            KIND_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count   = r_count - 1'b1;
                    n_removed = w_data[0];
                    for (int i = 0; i < DEPTH; i++) begin
                        w_ctrl[i].mode = MODE_FROM_RIGHT;
                    end
                end
            end
            KIND_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count   = r_count - 1'b1;
                    n_removed = w_back_data;
                end
            end
            KIND_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_count   = r_count - 1'b1;
                    n_removed = w_key;
                    // front match wins, then back match, then first match
                    for (int i = 0; i < DEPTH; i++) begin
                        rm = w_front_hit ? 1'b1 : (w_back_hit ? w_tail[i] : w_seen[i+1]);
                        if (rm) w_ctrl[i].mode = MODE_FROM_RIGHT;
                    end
                end
            end
            default: begin
            end
        endcase
        if (!w_go) begin
            n_count = r_count;
            for (int i = 0; i < DEPTH; i++) begin
                w_ctrl[i].mode = MODE_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_removed <= n_removed;
            r_status  <= n_status;
            r_occ     <= n_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_occupancy     = OCC_W'(r_occ);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> r_out_valid)
        else $error("accepted request gave no result");

    a_occ_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_occ == r_count))
        else $error("held occupancy differs from count");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && !w_full && (i_kind == KIND_PUSH_FRONT || i_kind == KIND_PUSH_BACK))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not grow the list");
`endif

endmodule

@@ dv/tb.sv @@
module tb
    import deq_pkg::*;
;

    localparam logic [KIND_W-1:0] KIND_MAX = '1;
    localparam t_data VAL_MIN = 32'h8000_0000;
    localparam t_data VAL_MAX = 32'h7fff_ffff;

    typedef struct {
        t_data              removed;
        logic [STAT_W-1:0]  status;
        logic [OCC_W-1:0]   occupancy;
    } t_deque_result;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    class t_deque_checker;
        t_data          held[$];            // predicted contents, front at index 0
        t_deque_result  awaited_results[$];
        int             errors;

        function void note_request(logic [KIND_W-1:0] kind, t_data value);
            t_deque_result r;
            int            n;
            int            pos;
            n = held.size();
            pos = -1;
            r.removed = '0;
            r.status = ST_OK;
            case (kind)
                KIND_PUSH_FRONT: begin
                    if (n >= DEPTH) r.status = ST_FULL;
                    else held.push_front(value);
                end
                KIND_PUSH_BACK: begin
                    if (n >= DEPTH) r.status = ST_FULL;
                    else held.push_back(value);
                end
                KIND_POP_FRONT: begin
                    if (n == 0) r.status = ST_EMPTY;
                    else r.removed = held.pop_front();
                end
                KIND_POP_BACK: begin
                    if (n == 0) r.status = ST_EMPTY;
                    else r.removed = held.pop_back();
                end
                KIND_REMOVE: begin
                    if (n == 0) begin
                        r.status = ST_EMPTY;
                    end else if (held[0] == value) begin
                        r.removed = held.pop_front();
                    end else if (held[n-1] == value) begin
                        r.removed = held.pop_back();
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            if (pos < 0 && held[i] == value) pos = i;
                        end
                        if (pos >= 0) begin
                            r.removed = held[pos];
                            held.delete(pos);
                        end else begin
                            r.status = ST_NOT_FOUND;
                        end
                    end
                end
                default: ;
            endcase
            r.occupancy = OCC_W'(held.size());
            awaited_results.push_back(r);
        endfunction

        function void check_result(t_data removed, logic [STAT_W-1:0] status,
                                   logic [OCC_W-1:0] occupancy);
            t_deque_result e;
            if (awaited_results.size() == 0) begin
                $display("%0t: result with nothing pending: removed %h status %0d occ %0d",
                         $time, removed, status, occupancy);
                errors++;
                return;
            end
            e = awaited_results.pop_front();
            if (removed !== e.removed) begin
                $display("%0t: removed_value expected %h actual %h", $time, e.removed, removed);
                errors++;
            end
            if (status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                errors++;
            end
            if (occupancy !== e.occupancy) begin
                $display("%0t: occupancy expected %0d actual %0d", $time, e.occupancy,
                         occupancy);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [KIND_W-1:0]        i_kind = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [DATA_W-1:0] o_removed_value;
    logic [STAT_W-1:0]        o_status;
    logic [OCC_W-1:0]         o_occupancy;

    int             sender_idle_pct = 7;
    int             receiver_idle_pct = 80;
    t_deque_checker deque_chk = new();

    deque_with_value_removal_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: check on each transaction, then decide next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            deque_chk.check_result(o_removed_value, o_status, o_occupancy);
        end
        i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic send_request(logic [KIND_W-1:0] kind, t_data value);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_value    <= value;
        do @(posedge i_clk); while (!o_in_ready);
        deque_chk.note_request(kind, value);
    endtask

    function automatic t_data pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return t_data'(int'($urandom_range(8)) - 4);
        if (r < 65) begin
            case ($urandom_range(3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '1;
                default: return '0;
            endcase
        end
        return $urandom();
    endfunction

    // removals mostly aim at something held so the search paths get exercised
    function automatic t_data pick_target();
        int n;
        n = deque_chk.held.size();
        if (n > 0 && $urandom_range(99) < 60) return deque_chk.held[$urandom_range(n - 1)];
        return pick_value();
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(int push_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4) return KIND_W'($urandom_range(KIND_REMOVE + 1, KIND_MAX));
        if (r < 4 + push_pct) return $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        case ($urandom_range(2))
            0:       return KIND_POP_FRONT;
            1:       return KIND_POP_BACK;
            default: return KIND_REMOVE;
        endcase
    endfunction

    task automatic run_random(int n_items);
        int                sent;
        int                burst;
        int                push_pct;
        t_mix              mix;
        logic [KIND_W-1:0] kind;
        sent = 0;
        mix = MIX_FILL;
        while (sent < n_items) begin
            case (mix)
                MIX_FILL:  push_pct = 80;
                MIX_DRAIN: push_pct = 25;
                default:   push_pct = 48;
            endcase
            burst = (mix == MIX_EVEN) ? $urandom_range(10, 30) : $urandom_range(25, 50);
            for (int i = 0; i < burst && sent < n_items; i++) begin
                kind = pick_kind(push_pct);
                send_request(kind, (kind == KIND_REMOVE) ? pick_target() : pick_value());
                sent++;
            end
            mix = t_mix'($urandom_range(2));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list and unused kinds, then pushes to set up the matches
        send_request(KIND_POP_FRONT, '0);
        send_request(KIND_POP_BACK, '0);
        send_request(KIND_REMOVE, '0);
        send_request(KIND_W'(KIND_REMOVE + 1), VAL_MAX);
        send_request(KIND_W'(KIND_REMOVE + 2), VAL_MIN);
        send_request(KIND_MAX, '1);
        send_request(KIND_PUSH_BACK, VAL_MIN);
        send_request(KIND_PUSH_FRONT, VAL_MAX);
        send_request(KIND_PUSH_BACK, '1);
        send_request(KIND_PUSH_BACK, '0);
        // front match, then back match
        send_request(KIND_REMOVE, VAL_MAX);
        send_request(KIND_REMOVE, '0);
        send_request(KIND_PUSH_BACK, 32'd7);
        send_request(KIND_PUSH_BACK, '1);
        // duplicate: back copy goes first, then the middle one
        send_request(KIND_REMOVE, '1);
        send_request(KIND_REMOVE, '1);
        send_request(KIND_REMOVE, 32'd12345);
        send_request(KIND_POP_BACK, '0);
        send_request(KIND_POP_FRONT, '0);
        send_request(KIND_W'(KIND_REMOVE + 1), '1);

        run_random(160);
        sender_idle_pct = 80;
        receiver_idle_pct = 7;
        run_random(170);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        run_random(170);
        i_in_valid <= 1'b0;

        while (deque_chk.pending() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (deque_chk.errors == 0) begin
            $display("deque_with_value_removal_core test passed");
        end else begin
            $display("deque_with_value_removal_core test failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("deque_with_value_removal_core test failed");
        $finish;
    end

endmodule
